// File: hw/rtl/frc_pkg.sv
package frc_pkg;

   // fixed-point format and bitmap limits
   localparam int FRAC_BITS = 4;
   localparam int MAX_DIM   = 2048;

   // field widths
   localparam int DIM_W     = 12;
   localparam int COORD_W   = 16;
   localparam int RAD_W     = 12;
   localparam int PIX_W     = 11;
   localparam int COLOR_W   = 32;
   localparam int CSR_IDX_W = 2;

   // derived widths
   localparam int SCAN_W  = RAD_W - FRAC_BITS;
   localparam int OFS_W   = SCAN_W + 1;
   localparam int CPX_W   = COORD_W - FRAC_BITS;
   localparam int ABS_W   = CPX_W + 1;
   localparam int LIMIT_W = 2 * RAD_W;
   localparam int CULL_W  = DIM_W + FRAC_BITS + 2;
   localparam int SQ_W    = 2 * SCAN_W;
   localparam int RSQ_W   = SQ_W + 1 + 2 * FRAC_BITS;

   // request commands
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BITMAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BITMAP_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_COLOR    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_COLOR    = 2'd3;

   // one classified request, handed from front to back
   typedef struct packed {
      logic                      is_step;
      logic                      done;
      logic signed [OFS_W-1:0]   ofs_x;
      logic signed [OFS_W-1:0]   ofs_y;
      logic signed [CPX_W-1:0]   cpx_x;
      logic signed [CPX_W-1:0]   cpx_y;
      logic        [LIMIT_W-1:0] inner;
      logic        [LIMIT_W-1:0] outer;
   } frc_job_type;

endpackage

// File: hw/rtl/frc_front.sv
module frc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           cmd,
   input  logic signed [frc_pkg::COORD_W-1:0] center_x,
   input  logic signed [frc_pkg::COORD_W-1:0] center_y,
   input  logic        [frc_pkg::RAD_W-1:0]   radius,
   input  logic        [frc_pkg::DIM_W-1:0]   width_eff,
   input  logic        [frc_pkg::DIM_W-1:0]   height_eff,
   output frc_pkg::frc_job_type           job
);
   import frc_pkg::*;

   localparam logic [RAD_W-1:0] ONE_PX = RAD_W'(1 << FRAC_BITS);

   logic                      busy_ff, busy_in;
   logic signed [CPX_W-1:0]   cpx_x_ff, cpx_x_in;
   logic signed [CPX_W-1:0]   cpx_y_ff, cpx_y_in;
   logic        [SCAN_W-1:0]  scan_radius_ff, scan_radius_in;
   logic signed [OFS_W-1:0]   ofs_x_ff, ofs_x_in;
   logic signed [OFS_W-1:0]   ofs_y_ff, ofs_y_in;
   logic        [LIMIT_W-1:0] inner_ff, inner_in;
   logic        [LIMIT_W-1:0] outer_ff, outer_in;

   logic signed [CULL_W-1:0]  cx_ext, cy_ext, r_ext, neg_r, wr_lim, hr_lim;
   logic                      culled;
   logic        [SCAN_W-1:0]  ir_cap;
   logic signed [CPX_W-1:0]   tx, ty;
   logic        [RAD_W-1:0]   d_abs;
   logic signed [OFS_W-1:0]   sr_s;
   logic                      at_x_end, at_y_end;

   // culling against the bitmap grown by the radius
   always_comb begin
      cx_ext = {{(CULL_W-COORD_W){center_x[COORD_W-1]}}, center_x};
      cy_ext = {{(CULL_W-COORD_W){center_y[COORD_W-1]}}, center_y};
      r_ext  = {{(CULL_W-RAD_W){1'b0}}, radius};
      neg_r  = -r_ext;
      wr_lim = {2'b00, width_eff, {FRAC_BITS{1'b0}}} + r_ext;
      hr_lim = {2'b00, height_eff, {FRAC_BITS{1'b0}}} + r_ext;
      culled = (cx_ext < neg_r) || (cx_ext > wr_lim) || (cy_ext < neg_r) || (cy_ext > hr_lim);
   end

   // scan radius, centre truncated toward zero, |radius - 1|
   always_comb begin
      ir_cap = radius[RAD_W-1:FRAC_BITS];
      if (DIM_W'(radius[RAD_W-1:FRAC_BITS]) > width_eff) begin
         ir_cap = width_eff[SCAN_W-1:0];
      end
      tx = center_x[COORD_W-1:FRAC_BITS]
         + CPX_W'(center_x[COORD_W-1] && (|center_x[FRAC_BITS-1:0]));
      ty = center_y[COORD_W-1:FRAC_BITS]
         + CPX_W'(center_y[COORD_W-1] && (|center_y[FRAC_BITS-1:0]));
      d_abs = (radius >= ONE_PX) ? (radius - ONE_PX) : (ONE_PX - radius);
   end

   always_comb begin
      sr_s     = {1'b0, scan_radius_ff};
      at_x_end = ofs_x_ff >= sr_s;
      at_y_end = ofs_y_ff >= sr_s;
   end

   always_comb begin
      busy_in        = busy_ff;
      cpx_x_in       = cpx_x_ff;
      cpx_y_in       = cpx_y_ff;
      scan_radius_in = scan_radius_ff;
      ofs_x_in       = ofs_x_ff;
      ofs_y_in       = ofs_y_ff;
      inner_in       = inner_ff;
      outer_in       = outer_ff;

      job.is_step = 1'b0;
      job.done    = 1'b1;
      job.ofs_x   = ofs_x_ff;
      job.ofs_y   = ofs_y_ff;
      job.cpx_x   = cpx_x_ff;
      job.cpx_y   = cpx_y_ff;
      job.inner   = inner_ff;
      job.outer   = outer_ff;

      if (cmd == CMD_START) begin
         job.done = culled;
         if (culled) begin
            busy_in = 1'b0;
         end else begin
            busy_in        = 1'b1;
            cpx_x_in       = tx;
            cpx_y_in       = ty;
            scan_radius_in = ir_cap;
            ofs_x_in       = -$signed({1'b0, ir_cap});
            ofs_y_in       = -$signed({1'b0, ir_cap});
            inner_in       = LIMIT_W'(d_abs) * LIMIT_W'(d_abs);
            outer_in       = LIMIT_W'(radius) * LIMIT_W'(radius);
         end
      end else if (busy_ff) begin
         job.is_step = 1'b1;
         job.done    = at_x_end && at_y_end;
         if (at_x_end && at_y_end) begin
            busy_in = 1'b0;
         end else if (at_x_end) begin
            ofs_x_in = -sr_s;
            ofs_y_in = ofs_y_ff + OFS_W'(1);
         end else begin
            ofs_x_in = ofs_x_ff + OFS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         cpx_x_ff       <= '0;
         cpx_y_ff       <= '0;
         scan_radius_ff <= '0;
         ofs_x_ff       <= '0;
         ofs_y_ff       <= '0;
         inner_ff       <= '0;
         outer_ff       <= '0;
      end else if (accept) begin
         busy_ff        <= busy_in;
         cpx_x_ff       <= cpx_x_in;
         cpx_y_ff       <= cpx_y_in;
         scan_radius_ff <= scan_radius_in;
         ofs_x_ff       <= ofs_x_in;
         ofs_y_ff       <= ofs_y_in;
         inner_ff       <= inner_in;
         outer_ff       <= outer_in;
      end
   end

endmodule

// File: hw/rtl/frc_queue.sv
module frc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  frc_pkg::frc_job_type push_job,
   output logic                 full,
   output logic                 head_valid,
   output frc_pkg::frc_job_type head_job,
   input  logic                 pop
);
   import frc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frc_job_type            mem [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// File: hw/rtl/frc_back.sv
module frc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  frc_pkg::frc_job_type         job,
   output logic                         job_pop,
   input  logic [frc_pkg::DIM_W-1:0]    width_eff,
   input  logic [frc_pkg::DIM_W-1:0]    height_eff,
   input  logic [frc_pkg::COLOR_W-1:0]  fill_color,
   input  logic [frc_pkg::COLOR_W-1:0]  line_color,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [frc_pkg::PIX_W-1:0]    rsp_pixel_x,
   output logic [frc_pkg::PIX_W-1:0]    rsp_pixel_y,
   output logic [frc_pkg::COLOR_W-1:0]  rsp_pixel_color,
   output logic                         rsp_write,
   output logic                         rsp_done_res
);
   import frc_pkg::*;

   // stage 1: squares and clipping
   logic                     s1_valid_ff;
   logic                     s1_step_ff, s1_done_ff, s1_inside_ff;
   logic [SQ_W-1:0]          s1_xsq_ff, s1_ysq_ff;
   logic [PIX_W-1:0]         s1_ax_ff, s1_ay_ff;
   logic [LIMIT_W-1:0]       s1_inner_ff, s1_outer_ff;

   logic [OFS_W-1:0]         abs_x, abs_y;
   logic signed [ABS_W-1:0]  ax, ay;
   logic                     inside_in;

   // stage 2: distance compare into the output register
   logic                     out_valid_ff;
   logic [PIX_W-1:0]         out_x_ff, out_y_ff;
   logic [COLOR_W-1:0]       out_color_ff;
   logic                     out_write_ff, out_done_ff;

   logic [SQ_W:0]            sq_sum;
   logic [RSQ_W-1:0]         rsq;
   logic                     hit, in_fill;
   logic                     out_move, s1_ready;

   assign out_move = !out_valid_ff || !rsp_stall;
   assign s1_ready = !s1_valid_ff || out_move;
   assign job_pop  = job_valid && s1_ready;

   always_comb begin
      abs_x = job.ofs_x[OFS_W-1] ? -job.ofs_x : job.ofs_x;
      abs_y = job.ofs_y[OFS_W-1] ? -job.ofs_y : job.ofs_y;
      ax = {job.cpx_x[CPX_W-1], job.cpx_x}
         + {{(ABS_W-OFS_W){job.ofs_x[OFS_W-1]}}, job.ofs_x};
      ay = {job.cpx_y[CPX_W-1], job.cpx_y}
         + {{(ABS_W-OFS_W){job.ofs_y[OFS_W-1]}}, job.ofs_y};
      inside_in = !ax[ABS_W-1] && (ax[ABS_W-2:0] < width_eff)
               && !ay[ABS_W-1] && (ay[ABS_W-2:0] < height_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (job_pop) begin
         s1_valid_ff <= 1'b1;
      end else if (out_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         s1_step_ff   <= job.is_step;
         s1_done_ff   <= job.done;
         s1_inside_ff <= inside_in;
         s1_xsq_ff    <= SQ_W'(abs_x[SCAN_W-1:0]) * SQ_W'(abs_x[SCAN_W-1:0]);
         s1_ysq_ff    <= SQ_W'(abs_y[SCAN_W-1:0]) * SQ_W'(abs_y[SCAN_W-1:0]);
         s1_ax_ff     <= ax[PIX_W-1:0];
         s1_ay_ff     <= ay[PIX_W-1:0];
         s1_inner_ff  <= job.inner;
         s1_outer_ff  <= job.outer;
      end
   end

   always_comb begin
      sq_sum  = {1'b0, s1_xsq_ff} + {1'b0, s1_ysq_ff};
      rsq     = {sq_sum, {(2*FRAC_BITS){1'b0}}};
      hit     = s1_step_ff && s1_inside_ff && (rsq <= RSQ_W'(s1_outer_ff));
      in_fill = rsq <= RSQ_W'(s1_inner_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_move) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_move) begin
         out_write_ff <= hit;
         out_done_ff  <= s1_done_ff;
         out_x_ff     <= hit ? s1_ax_ff : '0;
         out_y_ff     <= hit ? s1_ay_ff : '0;
         out_color_ff <= !hit ? '0 : (in_fill ? fill_color : line_color);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_write       = out_write_ff;
   assign rsp_done_res    = out_done_ff;

endmodule

// File: hw/rtl/filled_circle_rasterizer_unit.sv
// Filled circle rasterizer. A start request (cmd 0) loads a circle with a
// signed Q12.4 centre and an unsigned Q8.4 radius; a circle wholly outside
// the bitmap is culled and answers done at once. Each step request (cmd 1)
// visits one offset of the square around the centre in row order and
// answers with one response: a fill-colour pixel inside radius-1, a
// line-colour pixel on the ring, write 0 for offsets outside the circle or
// the bitmap, and done on the last offset. Every request gets exactly one
// response, in order. One request is taken per clock while the queue is
// not full; each request passes through the queue and then the two-stage
// squaring and compare pipeline in the back end. A queue of QUEUE_DEPTH
// entries sits between the scan sequencer and the pixel pipeline, so the
// request side keeps flowing while responses are stalled until the queue
// fills. The user must write registers (bitmap size, colours) through the
// csr port only while no request is in flight; the block doesn't enforce it.
module filled_circle_rasterizer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,

   // csr write port
   input  logic                                csr_wr_en,
   input  logic [frc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [frc_pkg::COLOR_W-1:0]         csr_wdata,

   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic signed [frc_pkg::COORD_W-1:0]  req_center_x,
   input  logic signed [frc_pkg::COORD_W-1:0]  req_center_y,
   input  logic        [frc_pkg::RAD_W-1:0]    req_radius,

   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [frc_pkg::PIX_W-1:0]           rsp_pixel_x,
   output logic [frc_pkg::PIX_W-1:0]           rsp_pixel_y,
   output logic [frc_pkg::COLOR_W-1:0]         rsp_pixel_color,
   output logic                                rsp_write,
   output logic                                rsp_done_res
);
   import frc_pkg::*;

   // configuration registers
   logic [DIM_W-1:0]   bitmap_width_ff, bitmap_height_ff;
   logic [COLOR_W-1:0] fill_color_ff, line_color_ff;

   // bitmap size limited to the largest supported bitmap
   logic [DIM_W-1:0]   width_eff, height_eff;

   logic               req_accept;
   frc_job_type        front_job, head_job;
   logic               q_full, q_valid, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_width_ff  <= DIM_W'(1024);
         bitmap_height_ff <= DIM_W'(1024);
         fill_color_ff    <= '0;
         line_color_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BITMAP_WIDTH:  bitmap_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_BITMAP_HEIGHT: bitmap_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_FILL_COLOR:    fill_color_ff    <= csr_wdata;
            CSR_LINE_COLOR:    line_color_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign width_eff  = (bitmap_width_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : bitmap_width_ff;
   assign height_eff = (bitmap_height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : bitmap_height_ff;

   // requests stall only when the queue is full
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   // front: culling, setup and the scan sequencer
   frc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .cmd        (req_cmd),
      .center_x   (req_center_x),
      .center_y   (req_center_y),
      .radius     (req_radius),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .job        (front_job)
   );

   frc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_job   (front_job),
      .full       (q_full),
      .head_valid (q_valid),
      .head_job   (head_job),
      .pop        (q_pop)
   );

   // back: distance test, clipping and the response register
   frc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (q_valid),
      .job             (head_job),
      .job_pop         (q_pop),
      .width_eff       (width_eff),
      .height_eff      (height_eff),
      .fill_color      (fill_color_ff),
      .line_color      (line_color_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_write       (rsp_write),
      .rsp_done_res    (rsp_done_res)
   );

endmodule

// File: dv/filled_circle_rasterizer_unit_tb.sv
`timescale 1ns / 100ps

module filled_circle_rasterizer_unit_tb;

   import frc_pkg::*;

   // watchdog and pressure settings
   localparam int STUCK_LIMIT      = 2000;
   localparam int LONG_HOLD_AT     = 60;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int MAX_REPORTS      = 10;

   // one request as the driver sees it
   typedef struct packed {
      logic                      cmd;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic        [RAD_W-1:0]   radius;
   } circle_req_type;

   // one response, field for field
   typedef struct packed {
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic [COLOR_W-1:0] pixel_color;
      logic               write;
      logic               done_res;
   } pixel_rsp_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // block inputs, all known from time zero
   logic                        csr_wr_en    = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index    = CSR_BITMAP_WIDTH;
   logic [COLOR_W-1:0]          csr_wdata    = '0;
   logic                        req_valid    = 1'b0;
   logic                        req_stall;
   logic                        req_cmd      = CMD_START;
   logic signed [COORD_W-1:0]   req_center_x = '0;
   logic signed [COORD_W-1:0]   req_center_y = '0;
   logic        [RAD_W-1:0]     req_radius   = '0;
   logic                        rsp_valid;
   logic                        rsp_stall    = 1'b1;
   logic [PIX_W-1:0]            rsp_pixel_x;
   logic [PIX_W-1:0]            rsp_pixel_y;
   logic [COLOR_W-1:0]          rsp_pixel_color;
   logic                        rsp_write;
   logic                        rsp_done_res;

   filled_circle_rasterizer_unit uut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius      (req_radius),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_write       (rsp_write),
      .rsp_done_res    (rsp_done_res)
   );

   // request source and expected responses
   circle_req_type pending_reqs[$];
   pixel_rsp_type  expected_pixels[$];
   int          reqs_pushed   = 0;
   int          reqs_accepted = 0;
   int          rsps_seen     = 0;
   int          bad_rsps      = 0;
   bit          req_idle_on   = 1'b0;
   bit          rsp_idle_on   = 1'b0;

   // register mirror, reset values
   logic [DIM_W-1:0]   bmp_width  = 12'd1024;
   logic [DIM_W-1:0]   bmp_height = 12'd1024;
   logic [COLOR_W-1:0] fill_rgba  = '0;
   logic [COLOR_W-1:0] line_rgba  = '0;

   // scan state of the circle being drawn
   bit          circle_busy = 1'b0;
   int          ctr_x       = 0;
   int          ctr_y       = 0;
   int          scan_rad    = 0;
   int          ofs_x       = 0;
   int          ofs_y       = 0;
   int unsigned inner_lim   = 0;
   int unsigned outer_lim   = 0;

   // bitmap size as used by the block, oversize registers limited
   function automatic int eff_dim(logic [DIM_W-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   // work out the response to one accepted request and advance the scan
   function automatic pixel_rsp_type rasterize_request(circle_req_type rq);
      int            w, h, cx, cy, r, wf, hf, ir, d, x, y, ax, ay;
      longint        dist2;
      pixel_rsp_type res;
      w   = eff_dim(bmp_width);
      h   = eff_dim(bmp_height);
      res = '0;
      if (rq.cmd == CMD_START) begin
         cx = rq.center_x;
         cy = rq.center_y;
         r  = rq.radius;
         wf = w << FRAC_BITS;
         hf = h << FRAC_BITS;
         // cull when the whole circle misses the bitmap
         if (cx < -r || cx > wf + r || cy < -r || cy > hf + r) begin
            circle_busy  = 1'b0;
            res.done_res = 1'b1;
         end else begin
            ir = r >> FRAC_BITS;
            if (ir > w) ir = w;
            // below one pixel this squares 1-radius, as the block does
            d           = r - (1 << FRAC_BITS);
            ctr_x       = cx / (1 << FRAC_BITS);
            ctr_y       = cy / (1 << FRAC_BITS);
            scan_rad    = ir;
            ofs_x       = -ir;
            ofs_y       = -ir;
            inner_lim   = d * d;
            outer_lim   = r * r;
            circle_busy = 1'b1;
         end
      end else if (!circle_busy) begin
         res.done_res = 1'b1;
      end else begin
         x     = ofs_x;
         y     = ofs_y;
         dist2 = longint'(x * x + y * y) << (2 * FRAC_BITS);
         ax    = ctr_x + x;
         ay    = ctr_y + y;
         // only pixels inside both the bitmap and the outer ring are written
         if (ax >= 0 && ax < w && ay >= 0 && ay < h && dist2 <= longint'(outer_lim)) begin
            res.write       = 1'b1;
            res.pixel_x     = PIX_W'(ax);
            res.pixel_y     = PIX_W'(ay);
            res.pixel_color = (dist2 <= longint'(inner_lim)) ? fill_rgba : line_rgba;
         end
         // row order: x inner, y outer, done on the last corner
         if (x >= scan_rad && y >= scan_rad) begin
            circle_busy  = 1'b0;
            res.done_res = 1'b1;
         end else if (x >= scan_rad) begin
            ofs_x = -scan_rad;
            ofs_y = y + 1;
         end else begin
            ofs_x = x + 1;
         end
      end
      return res;
   endfunction

   // wait after each handshake: half the time none, otherwise a random gap; none when disabled
   function automatic int draw_gap(bit enabled);
      if (!enabled || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   // request driver
   int             req_gap = 0;
   circle_req_type cur_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(rasterize_request(cur_req));
            reqs_accepted++;
            req_gap = draw_gap(req_idle_on);
         end
         // a stalled request holds its payload
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               cur_req = pending_reqs.pop_front();
               req_valid    <= 1'b1;
               req_cmd      <= cur_req.cmd;
               req_center_x <= cur_req.center_x;
               req_center_y <= cur_req.center_y;
               req_radius   <= cur_req.radius;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor, with one long hold-off to back the block up
   int rsp_gap   = 0;
   int hold_left = 0;

   always @(posedge clock) begin : rsp_monitor
      pixel_rsp_type got;
      pixel_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b1;
         rsp_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_write, rsp_done_res};
            if (expected_pixels.size() == 0) begin
               bad_rsps++;
               if (bad_rsps <= MAX_REPORTS)
                  $display("%0t: response with nothing expected: %s",
                           $realtime,
                           $sformatf("x=%0d y=%0d color=%h wr=%b done=%b",
                                     got.pixel_x, got.pixel_y, got.pixel_color,
                                     got.write, got.done_res));
            end else begin
               want = expected_pixels.pop_front();
               if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                   got.pixel_color !== want.pixel_color || got.write !== want.write ||
                   got.done_res !== want.done_res) begin
                  bad_rsps++;
                  if (bad_rsps <= MAX_REPORTS)
                     $display("%0t: mismatch: expected %s, got %s", $realtime,
                              $sformatf("x=%0d y=%0d color=%h wr=%b done=%b",
                                        want.pixel_x, want.pixel_y, want.pixel_color,
                                        want.write, want.done_res),
                              $sformatf("x=%0d y=%0d color=%h wr=%b done=%b",
                                        got.pixel_x, got.pixel_y, got.pixel_color,
                                        got.write, got.done_res));
               end
            end
            rsps_seen++;
            rsp_gap = draw_gap(rsp_idle_on);
            if (rsps_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   int stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
         $display("filled_circle_rasterizer_unit_tb NOT OK");
         $finish;
      end
   end

   task automatic push_request(logic cmd, int cx, int cy, int r);
      circle_req_type rq;
      rq.cmd      = cmd;
      rq.center_x = COORD_W'(cx);
      rq.center_y = COORD_W'(cy);
      rq.radius   = RAD_W'(r);
      pending_reqs.push_back(rq);
      reqs_pushed++;
   endtask

   // sender pause: everything accepted and answered
   task automatic wait_drained();
      while (reqs_accepted != reqs_pushed || expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_BITMAP_WIDTH:  bmp_width  = val[DIM_W-1:0];
         CSR_BITMAP_HEIGHT: bmp_height = val[DIM_W-1:0];
         CSR_FILL_COLOR:    fill_rgba  = val;
         default:           line_rgba  = val;
      endcase
   endtask

   // only called while idle; upper bits of the size writes are junk
   task automatic set_config(int w, int h, logic [COLOR_W-1:0] fill, logic [COLOR_W-1:0] line);
      write_reg(CSR_BITMAP_WIDTH,  ($urandom & 32'hFFFF_F000) | COLOR_W'(w));
      write_reg(CSR_BITMAP_HEIGHT, ($urandom & 32'hFFFF_F000) | COLOR_W'(h));
      write_reg(CSR_FILL_COLOR,    fill);
      write_reg(CSR_LINE_COLOR,    line);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // centre in Q12.4 within a couple of pixels of the culling border
   function automatic int pick_coord(int dim, int rp);
      int lo, v;
      lo = -((rp + 2) << FRAC_BITS);
      v  = lo + int'($urandom_range(0, (dim + 2 * rp + 4) << FRAC_BITS));
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   // one start and its scan; sometimes cut short, sometimes run past done
   task automatic queue_circle(int max_px);
      int w, h, rp, side, steps;
      w = eff_dim(bmp_width);
      h = eff_dim(bmp_height);
      if ($urandom_range(0, 24) == 0) rp = $urandom_range(max_px + 1, 255);
      else rp = $urandom_range(0, max_px);
      push_request(CMD_START, pick_coord(w, rp), pick_coord(h, rp),
                   (rp << FRAC_BITS) | $urandom_range(0, 15));
      side  = 2 * ((rp > w) ? w : rp) + 1;
      steps = side * side;
      // big circles get a random run of steps, abandoned by the next start unless a narrow bitmap caps the scan small
      if (rp > max_px) begin
         steps = $urandom_range(1, 40);
      end else begin
         case ($urandom_range(0, 7))
            0:       steps = $urandom_range(0, steps - 1);
            1:       steps += $urandom_range(1, 3);
            default: ;
         endcase
      end
      repeat (steps) push_request(CMD_STEP, $urandom, $urandom, $urandom);
   endtask

   task automatic run_random(int n_items, int max_px, bit req_idle, bit rsp_idle);
      int stop_at;
      req_idle_on = req_idle;
      rsp_idle_on = rsp_idle;
      stop_at = reqs_pushed + n_items;
      while (reqs_pushed < stop_at) begin
         // noise: fully random starts and stray steps
         if ($urandom_range(0, 6) == 0) begin
            if ($urandom_range(0, 1) == 0)
               push_request(CMD_STEP, $urandom, $urandom, $urandom);
            else
               push_request(CMD_START, $urandom, $urandom, $urandom);
         end else begin
            queue_circle(max_px);
         end
      end
      wait_drained();
   endtask

   initial begin
      logic [COLOR_W-1:0] fill;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: step while idle, sub-pixel circle at the origin
      push_request(CMD_STEP, 0, 0, 0);
      push_request(CMD_START, 0, 0, 0);
      push_request(CMD_STEP, -1, -1, 4095);
      wait_drained();

      // directed part on a small bitmap with distinct colours
      fill = $urandom;
      set_config(16, 16, fill, ~fill);
      push_request(CMD_START, 8 * 16 + 5, 8 * 16 + 9, 24);
      repeat (9) push_request(CMD_STEP, 0, 0, 0);
      // culled starts at the field extremes
      push_request(CMD_START, -32768, 0, 0);
      push_request(CMD_START, 32767, 32767, 4095);
      push_request(CMD_START, -32768, -32768, 4095);
      // largest radius, scan capped at the width, abandoned by a new start
      push_request(CMD_START, 4 * 16 + 3, 12 * 16 + 15, 4095);
      repeat (3) push_request(CMD_STEP, 32'hFFFF, 32'hFFFF, 32'hFFF);
      // negative centre truncates toward zero, radius under one pixel
      push_request(CMD_START, -5, -7, 8);
      repeat (2) push_request(CMD_STEP, 0, 0, 0);
      wait_drained();

      // largest bitmap, sender never idles so the long hold fills the block
      set_config(2048, 2048, $urandom, $urandom);
      run_random(150, 4, 1'b0, 1'b1);

      // one-pixel bitmap
      set_config(1, 1, $urandom, $urandom);
      run_random(100, 3, 1'b1, 1'b1);

      // empty width, oversize height
      set_config(0, 4095, $urandom, $urandom);
      run_random(60, 3, 1'b1, 1'b0);

      // small bitmap, no idling on either side
      set_config($urandom_range(8, 64), $urandom_range(8, 64), $urandom, $urandom);
      run_random(150, 5, 1'b0, 1'b0);

      // arbitrary sizes
      set_config($urandom_range(1, 2048), $urandom_range(1, 2048), $urandom, $urandom);
      run_random(150, 4, 1'b1, 1'b1);

      // colour extremes
      set_config($urandom_range(20, 40), $urandom_range(20, 40), 32'h0, 32'hFFFF_FFFF);
      run_random(140, 4, 1'b1, 1'b1);

      repeat (16) @(posedge clock);
      if (bad_rsps == 0 && expected_pixels.size() == 0)
         $display("filled_circle_rasterizer_unit_tb OK");
      else
         $display("filled_circle_rasterizer_unit_tb NOT OK");
      $finish;
   end

endmodule
